// ===== rtl/cse_pkg.sv =====
package cse_pkg;

  localparam int CoordW    = 32;
  localparam int HalfW     = CoordW - 1;
  localparam int UnitBits  = 30;
  localparam int BW        = UnitBits + 1;
  localparam int SqW       = 2 * BW;
  localparam int SumW      = 64;
  localparam int LenW      = 32;
  localparam int NumW      = BW + UnitBits + 1;
  localparam int SqrtSteps = SumW / 2;
  localparam int DivSteps  = BW;
  localparam int ProdW     = BW + HalfW;

  typedef struct packed {
    logic [2:0][CoordW-1:0] cen;
    logic [HalfW-1:0]       hh;
    logic [2:0]             aneg;
    logic                   degen;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [2:0][BW-1:0] b;
    logic [SumW-1:0]    rem;
    logic [SumW-1:0]    res;
  } sqrt_t;

  typedef struct packed {
    side_t                side;
    logic [LenW-1:0]      len;
    logic [2:0][LenW-1:0] rem;
    logic [2:0][BW-1:0]   nlo;
    logic [2:0][BW-1:0]   quo;
  } div_t;

endpackage

// ===== rtl/capsule_segment_endpoints_unit.sv =====
// capsule segment endpoints
// takes one capsule per request (center, axis, half height, signed Q16.16)
// and returns the two core segment endpoints: center +/- unit axis * half
// height, each coordinate saturated, plus a flag that is set when the axis
// was all zero and (0,1,0) was used in its place.
// both channels use valid/stall: a request moves on a rising edge where
// valid is high and stall is low.
// there are 72 register stages; one request can be accepted every cycle while
// stall_o is low. the depth is set by the square root of the squared axis
// length (sum stage plus one result bit per stage, 32 stages) and the three
// divisions by that length (setup stage plus one quotient bit per stage,
// 31 stages).
// when the receiver stalls a waiting result, a skid register catches the
// request that is already on its way and stall_o rises the next cycle; the
// pipeline then holds until the result is taken. stall_o comes from a
// register, so it never follows stall_i in the same cycle.
// reset clears every valid bit, so the pipeline comes up empty; data
// registers are not reset.
module capsule_segment_endpoints_unit import cse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [CoordW-1:0] center_x_i,
  input  logic [CoordW-1:0] center_y_i,
  input  logic [CoordW-1:0] center_z_i,
  input  logic [CoordW-1:0] axis_x_i,
  input  logic [CoordW-1:0] axis_y_i,
  input  logic [CoordW-1:0] axis_z_i,
  input  logic [HalfW-1:0]  half_height_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [CoordW-1:0] top_x_o,
  output logic [CoordW-1:0] top_y_o,
  output logic [CoordW-1:0] top_z_o,
  output logic [CoordW-1:0] bottom_x_o,
  output logic [CoordW-1:0] bottom_y_o,
  output logic [CoordW-1:0] bottom_z_o,
  output logic              degenerate_axis_o
);

  localparam logic signed [CoordW+1:0] SatHi = (CoordW+2)'((64'd1 << (CoordW - 1)) - 64'd1);
  localparam logic signed [CoordW+1:0] SatLo = -SatHi - (CoordW+2)'(1);

  function automatic logic [CoordW-1:0] sat(input logic signed [CoordW+1:0] v);
    logic [CoordW-1:0] r;
    if (v > SatHi) r = SatHi[CoordW-1:0];
    else if (v < SatLo) r = SatLo[CoordW-1:0];
    else r = v[CoordW-1:0];
    return r;
  endfunction

  logic adv;
  logic out_v_q;
  logic out_en;
  logic skid_v_q;

  assign stall_o = skid_v_q;
  assign adv     = !skid_v_q;
  assign out_en  = !out_v_q || !stall_i;
  assign valid_o = out_v_q;

  // stage a: magnitudes
  logic [2:0][CoordW-1:0] in_axis, in_mag;
  side_t                  in_side;
  logic                   a_v_q;
  side_t                  a_side_q;
  logic [2:0][CoordW-1:0] a_mag_q;

  always_comb begin
    in_axis = {axis_z_i, axis_y_i, axis_x_i};
    in_side.cen   = {center_z_i, center_y_i, center_x_i};
    in_side.hh    = half_height_i;
    in_side.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      in_side.aneg[i] = in_axis[i][CoordW-1];
      in_mag[i] = in_axis[i][CoordW-1] ? (~in_axis[i] + CoordW'(1)) : in_axis[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q <= in_side;
      a_mag_q  <= in_mag;
    end
  end

  // stage b: largest magnitude and its top bit
  logic [CoordW-1:0] maxm;
  logic [4:0]        top_pos;
  side_t             b_side_d;
  logic              b_v_q;
  side_t             b_side_q;
  logic [2:0][CoordW-1:0] b_mag_q;
  logic [4:0]        b_pos_q;

  always_comb begin
    maxm = a_mag_q[0];
    if (a_mag_q[1] > maxm) maxm = a_mag_q[1];
    if (a_mag_q[2] > maxm) maxm = a_mag_q[2];
    top_pos = '0;
    for (int i = 0; i < CoordW; i++) begin
      if (maxm[i]) top_pos = 5'(i);
    end
    b_side_d = a_side_q;
    b_side_d.degen = (maxm == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_side_q <= b_side_d;
      b_mag_q  <= a_mag_q;
      b_pos_q  <= top_pos;
    end
  end

  // stage c: block normalize so the largest has its top bit at bit 30
  logic [2:0][BW-1:0] c_b_d;
  logic               c_v_q;
  side_t              c_side_q;
  logic [2:0][BW-1:0] c_b_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_pos_q < 5'(UnitBits))
        c_b_d[i] = BW'(b_mag_q[i] << (5'(UnitBits) - b_pos_q));
      else
        c_b_d[i] = BW'(b_mag_q[i] >> (b_pos_q - 5'(UnitBits)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_side_q <= b_side_q;
      c_b_q    <= c_b_d;
    end
  end

  // stage d: squares
  logic                d_v_q;
  side_t               d_side_q;
  logic [2:0][BW-1:0]  d_b_q;
  logic [2:0][SqW-1:0] d_sq_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_side_q <= c_side_q;
      d_b_q    <= c_b_q;
      for (int i = 0; i < 3; i++) d_sq_q[i] <= SqW'(c_b_q[i]) * SqW'(c_b_q[i]);
    end
  end

  // square root, one result bit per stage; stage 0 holds the sum
  logic  sq_v_q [0:SqrtSteps];
  sqrt_t sq_q   [0:SqrtSteps];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].side <= d_side_q;
      sq_q[0].b    <= d_b_q;
      sq_q[0].rem  <= SumW'(d_sq_q[0]) + SumW'(d_sq_q[1]) + SumW'(d_sq_q[2]);
      sq_q[0].res  <= '0;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SumW-1:0] Bit = SumW'(1) << (SumW - 2 - 2 * k);
    logic [SumW-1:0] trial;
    sqrt_t           nxt;

    always_comb begin
      trial = sq_q[k].res + Bit;
      nxt   = sq_q[k];
      if (sq_q[k].rem >= trial) begin
        nxt.rem = sq_q[k].rem - trial;
        nxt.res = (sq_q[k].res >> 1) + Bit;
      end else begin
        nxt.res = sq_q[k].res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) sq_q[k+1] <= nxt;
    end
  end

  // division setup: numerator b * 2^30 + len / 2
  logic  dv_v_q [0:DivSteps];
  div_t  dv_q   [0:DivSteps];
  div_t  dv_init;
  logic [LenW-1:0]   root_len;
  logic [NumW-1:0]   num [3];

  always_comb begin
    root_len = (sq_q[SqrtSteps].res == '0) ? LenW'(1) : sq_q[SqrtSteps].res[LenW-1:0];
    dv_init.side = sq_q[SqrtSteps].side;
    dv_init.len  = root_len;
    dv_init.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      num[i] = NumW'({sq_q[SqrtSteps].b[i], UnitBits'(0)}) + NumW'(root_len[LenW-1:1]);
      dv_init.rem[i] = LenW'(num[i][NumW-1:BW]);
      dv_init.nlo[i] = num[i][BW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) dv_q[0] <= dv_init;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [LenW:0] trial [3];
    logic [LenW:0] diff  [3];
    div_t          nxt;

    always_comb begin
      nxt = dv_q[j];
      for (int i = 0; i < 3; i++) begin
        trial[i] = {dv_q[j].rem[i], dv_q[j].nlo[i][BW-1]};
        diff[i]  = trial[i] - {1'b0, dv_q[j].len};
        nxt.nlo[i] = dv_q[j].nlo[i] << 1;
        if (trial[i] >= {1'b0, dv_q[j].len}) begin
          nxt.rem[i] = diff[i][LenW-1:0];
          nxt.quo[i] = {dv_q[j].quo[i][BW-2:0], 1'b1};
        end else begin
          nxt.rem[i] = trial[i][LenW-1:0];
          nxt.quo[i] = {dv_q[j].quo[i][BW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) dv_q[j+1] <= nxt;
    end
  end

  // stage m: unit component times half height
  logic [2:0][BW-1:0]   unit_c;
  side_t                m_side_d;
  logic                 m_v_q;
  side_t                m_side_q;
  logic [2:0][ProdW-1:0] m_prod_q;

  always_comb begin
    m_side_d      = dv_q[DivSteps].side;
    m_side_d.aneg = dv_q[DivSteps].side.aneg & {3{!dv_q[DivSteps].side.degen}};
    for (int i = 0; i < 3; i++) begin
      if (dv_q[DivSteps].side.degen)
        unit_c[i] = (i == 1) ? (BW'(1) << UnitBits) : '0;
      else
        unit_c[i] = dv_q[DivSteps].quo[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_side_q <= m_side_d;
      for (int i = 0; i < 3; i++)
        m_prod_q[i] <= ProdW'(unit_c[i]) * ProdW'(dv_q[DivSteps].side.hh);
    end
  end

  // stage o: round the offset back to the coordinate format
  logic                   o_v_q;
  side_t                  o_side_q;
  logic [2:0][CoordW-1:0] o_off_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_side_q <= m_side_q;
      for (int i = 0; i < 3; i++)
        o_off_q[i] <= CoordW'((m_prod_q[i] + (ProdW'(1) << (UnitBits - 1))) >> UnitBits);
    end
  end

  // output stage: add, subtract, saturate
  logic signed [CoordW+1:0] cen_w [3];
  logic signed [CoordW+1:0] off_w [3];
  logic [2:0][CoordW-1:0]   top_d, bot_d;
  logic [2:0][CoordW-1:0]   top_q, bot_q;
  logic                     degen_q;
  logic [2:0][CoordW-1:0]   skid_top_q, skid_bot_q;
  logic                     skid_degen_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cen_w[i] = (CoordW+2)'($signed(o_side_q.cen[i]));
      off_w[i] = o_side_q.aneg[i] ? -$signed({2'b00, o_off_q[i]})
                                  : $signed({2'b00, o_off_q[i]});
      top_d[i] = sat(cen_w[i] + off_w[i]);
      bot_d[i] = sat(cen_w[i] - off_w[i]);
    end
  end

  // skid register takes the request in flight while the output waits
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      if (skid_v_q) begin
        top_q   <= skid_top_q;
        bot_q   <= skid_bot_q;
        degen_q <= skid_degen_q;
      end else begin
        top_q   <= top_d;
        bot_q   <= bot_d;
        degen_q <= o_side_q.degen;
      end
    end else if (adv && o_v_q) begin
      skid_top_q   <= top_d;
      skid_bot_q   <= bot_d;
      skid_degen_q <= o_side_q.degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q  <= skid_v_q || o_v_q;
      skid_v_q <= 1'b0;
    end else if (adv && o_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  assign top_x_o           = top_q[0];
  assign top_y_o           = top_q[1];
  assign top_z_o           = top_q[2];
  assign bottom_x_o        = bot_q[0];
  assign bottom_y_o        = bot_q[1];
  assign bottom_z_o        = bot_q[2];
  assign degenerate_axis_o = degen_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      m_v_q   <= 1'b0;
      o_v_q   <= 1'b0;
      for (int k = 0; k <= SqrtSteps; k++) sq_v_q[k] <= 1'b0;
      for (int j = 0; j <= DivSteps; j++) dv_v_q[j] <= 1'b0;
    end else if (adv) begin
      a_v_q     <= valid_i;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q;
      d_v_q     <= c_v_q;
      sq_v_q[0] <= d_v_q;
      for (int k = 0; k < SqrtSteps; k++) sq_v_q[k+1] <= sq_v_q[k];
      dv_v_q[0] <= sq_v_q[SqrtSteps];
      for (int j = 0; j < DivSteps; j++) dv_v_q[j+1] <= dv_v_q[j];
      m_v_q     <= dv_v_q[DivSteps];
      o_v_q     <= m_v_q;
    end
  end

  // square root remainder never exceeds twice the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[SqrtSteps] |-> sq_q[SqrtSteps].rem <= (sq_q[SqrtSteps].res << 1))
    else $error("square root remainder out of range");

  // division remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[DivSteps] |-> dv_q[DivSteps].rem[0] < dv_q[DivSteps].len &&
                         dv_q[DivSteps].rem[1] < dv_q[DivSteps].len &&
                         dv_q[DivSteps].rem[2] < dv_q[DivSteps].len)
    else $error("division remainder not below divisor");

  // a unit component never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[DivSteps] && !dv_q[DivSteps].side.degen |->
      dv_q[DivSteps].quo[0] <= (BW'(1) << UnitBits) &&
      dv_q[DivSteps].quo[1] <= (BW'(1) << UnitBits) &&
      dv_q[DivSteps].quo[2] <= (BW'(1) << UnitBits))
    else $error("unit component above one");

  // with the substituted axis only y moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && degen_q |-> top_q[0] == bot_q[0] && top_q[2] == bot_q[2])
    else $error("degenerate axis moved x or z");

  // the skid register only fills behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full with empty output");

endmodule
